// ----- design/ami_pkg.sv -----
// shared types and constants of the affine 3x4 matrix inverse
// no dependencies; imported by affine_matrix_inverse
package ami_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned POS_W          = 4;
    localparam int unsigned NUM_COF        = 9;

    localparam logic [POS_W-1:0] FIRST_POS = 4'd0;
    localparam logic [POS_W-1:0] LAST_POS  = 4'd11;

    typedef logic [3:0] t_idx;

    // cofactor k = a[PA]*a[PB] - a[SA]*a[SB], a in row-major 3x3 order
    localparam t_idx COF_PA [NUM_COF] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_PB [NUM_COF] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_SA [NUM_COF] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_SB [NUM_COF] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    // sideband that travels with each quotient through the divider
    typedef struct packed {
        logic             neg;
        logic             sing;
        logic             last;
        logic [POS_W-1:0] pos;
    } t_tag;

endpackage

// ----- design/affine_matrix_inverse.sv -----
// inverse of a row-major 3x4 affine matrix in signed fixed point
// depends on ami_pkg for defaults, cofactor index tables and the result tag
//
// usage: drive the twelve matrix elements and raise i_start; the matrix is
// taken at a rising edge where i_start is high and o_busy is low. o_busy is
// high after each accepted matrix while the busy counter runs down from
// LAST_POS, so a new matrix can be taken while earlier results are in flight.
// results: one per cycle, marked by o_valid for exactly one cycle, in
// position order 0..11 with o_last on position 11. A matrix with zero
// determinant gives one result: value 0, position 0, o_singular and o_last.
// pipeline: the results pass six front stages of capture, multiply and
// accumulate, a hold stage for the issuer, an issue and a magnitude stage,
// an overflow check stage, a divider that resolves one quotient bit per
// stage over DATA_WIDTH + 1 stages, and the output register.
// the receiver cannot stall; every result must be taken when it appears.
// reset (i_rst_n low at an edge) clears all valid bits and the busy counter;
// transactions in flight are dropped.
module affine_matrix_inverse #(
    parameter int unsigned DATA_WIDTH = ami_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = ami_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [DATA_WIDTH-1:0]  i_r0c0,
    input  logic signed [DATA_WIDTH-1:0]  i_r0c1,
    input  logic signed [DATA_WIDTH-1:0]  i_r0c2,
    input  logic signed [DATA_WIDTH-1:0]  i_r0c3,
    input  logic signed [DATA_WIDTH-1:0]  i_r1c0,
    input  logic signed [DATA_WIDTH-1:0]  i_r1c1,
    input  logic signed [DATA_WIDTH-1:0]  i_r1c2,
    input  logic signed [DATA_WIDTH-1:0]  i_r1c3,
    input  logic signed [DATA_WIDTH-1:0]  i_r2c0,
    input  logic signed [DATA_WIDTH-1:0]  i_r2c1,
    input  logic signed [DATA_WIDTH-1:0]  i_r2c2,
    input  logic signed [DATA_WIDTH-1:0]  i_r2c3,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_value,
    output logic [ami_pkg::POS_W-1:0]     o_position,
    output logic                          o_singular,
    output logic                          o_last
);
    import ami_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int CW  = 2 * W + 1;
    localparam int TW  = 3 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NTW = 3 * W + 4;
    localparam int NCS = CW + 2 * F;
    localparam int NTS = NTW + F;
    localparam int NW  = (NCS > NTS) ? NCS : NTS;
    localparam int QB  = W + 1;
    localparam int HW  = ((NW - QB) > DW) ? (NW - QB) : DW;

    // accept and busy counter
    logic             n_accept;
    logic [POS_W-1:0] r_gap;

    assign n_accept = i_start & ~o_busy;
    assign o_busy   = (r_gap != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (n_accept) begin
            r_gap <= LAST_POS;
        end else if (r_gap != '0) begin
            r_gap <= r_gap - 1'b1;
        end
    end

    // stage 1: input capture
    logic signed [W-1:0] r_a [9];
    logic signed [W-1:0] r_t [3];
    logic                r_v1;

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_a[0] <= i_r0c0;
            r_a[1] <= i_r0c1;
            r_a[2] <= i_r0c2;
            r_a[3] <= i_r1c0;
            r_a[4] <= i_r1c1;
            r_a[5] <= i_r1c2;
            r_a[6] <= i_r2c0;
            r_a[7] <= i_r2c1;
            r_a[8] <= i_r2c2;
            r_t[0] <= i_r0c3;
            r_t[1] <= i_r1c3;
            r_t[2] <= i_r2c3;
        end
    end

    // stage 2: the eighteen 2x2 minor products
    logic signed [PW-1:0] r_p  [9];
    logic signed [PW-1:0] r_s  [9];
    logic signed [W-1:0]  r_t2 [3];
    logic signed [W-1:0]  r_a2 [3];
    logic                 r_v2;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_COF; k++) begin
            r_p[k] <= PW'(r_a[COF_PA[k]]) * PW'(r_a[COF_PB[k]]);
            r_s[k] <= PW'(r_a[COF_SA[k]]) * PW'(r_a[COF_SB[k]]);
        end
        for (int i = 0; i < 3; i++) begin
            r_t2[i] <= r_t[i];
            r_a2[i] <= r_a[i];
        end
    end

    // stage 3: cofactors
    logic signed [CW-1:0] r_c3 [9];
    logic signed [W-1:0]  r_t3 [3];
    logic signed [W-1:0]  r_a3 [3];
    logic                 r_v3;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_COF; k++) begin
            r_c3[k] <= CW'(r_p[k]) - CW'(r_s[k]);
        end
        for (int i = 0; i < 3; i++) begin
            r_t3[i] <= r_t2[i];
            r_a3[i] <= r_a2[i];
        end
    end

    // stage 4: partial products, cofactor split into signed high and unsigned low halves
    logic signed [CW-1:0] r_dh [3];
    logic signed [CW-1:0] r_dl [3];
    logic signed [CW-1:0] r_th [9];
    logic signed [CW-1:0] r_tl [9];
    logic signed [CW-1:0] r_c4 [9];
    logic                 r_v4;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dh[i] <= CW'(r_a3[i]) * CW'($signed(r_c3[i*3][CW-1:W]));
            r_dl[i] <= CW'(r_a3[i]) * CW'($signed({1'b0, r_c3[i*3][W-1:0]}));
        end
        for (int k = 0; k < NUM_COF; k++) begin
            r_th[k] <= CW'(r_t3[k%3]) * CW'($signed(r_c3[k][CW-1:W]));
            r_tl[k] <= CW'(r_t3[k%3]) * CW'($signed({1'b0, r_c3[k][W-1:0]}));
            r_c4[k] <= r_c3[k];
        end
    end

    // stage 5: recombine halves into full terms
    logic signed [TW-1:0] r_dterm [3];
    logic signed [TW-1:0] r_tterm [9];
    logic signed [CW-1:0] r_c5    [9];
    logic                 r_v5;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dterm[i] <= (TW'(r_dh[i]) <<< W) + TW'(r_dl[i]);
        end
        for (int k = 0; k < NUM_COF; k++) begin
            r_tterm[k] <= (TW'(r_th[k]) <<< W) + TW'(r_tl[k]);
            r_c5[k]    <= r_c4[k];
        end
    end

    // stage 6: determinant and negated translation numerators
    logic signed [DW-1:0]  r_det;
    logic signed [NTW-1:0] r_tn [3];
    logic signed [CW-1:0]  r_c6 [9];
    logic                  r_v6;

    always_ff @(posedge i_clk) begin
        r_det <= DW'(r_dterm[0]) + DW'(r_dterm[1]) + DW'(r_dterm[2]);
        for (int r = 0; r < 3; r++) begin
            r_tn[r] <= '0 - (NTW'(r_tterm[r*3]) + NTW'(r_tterm[r*3+1])
                           + NTW'(r_tterm[r*3+2]));
        end
        for (int k = 0; k < NUM_COF; k++) begin
            r_c6[k] <= r_c5[k];
        end
    end

    // front pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= n_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // hold registers for the matrix being issued
    logic signed [CW-1:0]  r_hc [9];
    logic signed [NTW-1:0] r_htn [3];
    logic [DW-1:0]         r_hdmag;
    logic                  r_hdneg;
    logic                  r_hsing;

    always_ff @(posedge i_clk) begin
        if (r_v6) begin
            for (int k = 0; k < NUM_COF; k++) begin
                r_hc[k] <= r_c6[k];
            end
            for (int r = 0; r < 3; r++) begin
                r_htn[r] <= r_tn[r];
            end
            r_hdneg <= r_det[DW-1];
            r_hdmag <= r_det[DW-1] ? DW'('0 - r_det) : DW'(r_det);
            r_hsing <= (r_det == '0);
        end
    end

    // issue sequencer, one position per cycle
    logic             r_act;
    logic [POS_W-1:0] r_pos;
    logic             n_act;
    logic [POS_W-1:0] n_pos;
    logic [1:0]       n_row;
    logic [1:0]       n_col;
    logic [3:0]       n_cidx;
    logic signed [NW-1:0] n_num;
    t_tag             n_itag;

    always_comb begin
        n_act = r_act;
        n_pos = r_pos;
        if (r_v6) begin
            n_act = 1'b1;
            n_pos = FIRST_POS;
        end else if (r_act) begin
            if (r_hsing || r_pos == LAST_POS) begin
                n_act = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_pos <= FIRST_POS;
        end else begin
            r_act <= n_act;
            r_pos <= n_pos;
        end
    end

    // numerator select: cofactor scaled by 2F, or translation sum scaled by F
    always_comb begin
        n_row  = r_pos[3:2];
        n_col  = r_pos[1:0];
        n_cidx = 4'(n_row) * 4'd3 + ((n_col == 2'd3) ? 4'd0 : 4'(n_col));
        if (n_col == 2'd3) begin
            n_num = NW'(r_htn[n_row]) <<< F;
        end else begin
            n_num = NW'(r_hc[n_cidx]) <<< (2 * F);
        end
        n_itag.neg  = 1'b0;
        n_itag.sing = r_hsing;
        n_itag.last = r_hsing || (r_pos == LAST_POS);
        n_itag.pos  = r_pos;
    end

    logic                 r_iv;
    logic signed [NW-1:0] r_inum;
    logic [DW-1:0]        r_id;
    logic                 r_idneg;
    t_tag                 r_itag;

    always_ff @(posedge i_clk) begin
        r_inum  <= n_num;
        r_id    <= r_hdmag;
        r_idneg <= r_hdneg;
        r_itag  <= n_itag;
    end

    // magnitude stage
    logic          r_bv;
    logic [NW-1:0] r_bnum;
    logic [DW-1:0] r_bd;
    t_tag          r_btag;

    always_ff @(posedge i_clk) begin
        r_bnum <= r_inum[NW-1] ? NW'('0 - r_inum) : NW'(r_inum);
        r_bd   <= r_id;
        r_btag <= '{neg: r_inum[NW-1] ^ r_idneg, sing: r_itag.sing,
                    last: r_itag.last, pos: r_itag.pos};
    end

    // divider pipeline: stage 0 checks for overflow, then one quotient bit a stage
    logic          r_dv  [QB+1];
    logic [DW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_low [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_big [QB+1];
    logic [DW-1:0] r_dd  [QB+1];
    t_tag          r_dtag[QB+1];
    logic [HW-1:0] n_hin;

    assign n_hin = HW'(r_bnum >> QB);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_hin[DW-1:0];
        r_low[0]  <= r_bnum[QB-1:0];
        r_q[0]    <= '0;
        r_big[0]  <= (n_hin >= HW'(r_bd));
        r_dd[0]   <= r_bd;
        r_dtag[0] <= r_btag;
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [DW:0] n_trial;
        logic [DW:0] n_diff;
        logic        n_ge;

        assign n_trial = {r_rem[j], r_low[j][QB-1]};
        assign n_diff  = n_trial - {1'b0, r_dd[j]};
        assign n_ge    = ~n_diff[DW];

        always_ff @(posedge i_clk) begin
            r_rem[j+1]  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_low[j+1]  <= r_low[j] << 1;
            r_q[j+1]    <= {r_q[j][QB-2:0], n_ge};
            r_big[j+1]  <= r_big[j];
            r_dd[j+1]   <= r_dd[j];
            r_dtag[j+1] <= r_dtag[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end
    end

    // back pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_bv    <= 1'b0;
            r_dv[0] <= 1'b0;
        end else begin
            r_iv    <= r_act;
            r_bv    <= r_iv;
            r_dv[0] <= r_bv;
        end
    end

    // sign and saturation to the output format
    logic [QB-1:0] n_qf;
    t_tag          n_tf;
    logic          n_povf;
    logic          n_novf;
    logic [W-1:0]  n_val;

    always_comb begin
        n_qf   = r_q[QB];
        n_tf   = r_dtag[QB];
        n_povf = r_big[QB] | n_qf[W] | n_qf[W-1];
        n_novf = r_big[QB] | n_qf[W] | (n_qf[W-1] & (|n_qf[W-2:0]));
        if (n_tf.sing) begin
            n_val = '0;
        end else if (!n_tf.neg) begin
            n_val = n_povf ? {1'b0, {(W-1){1'b1}}} : n_qf[W-1:0];
        end else begin
            n_val = n_novf ? {1'b1, {(W-1){1'b0}}} : ('0 - n_qf[W-1:0]);
        end
    end

    // output register
    logic             r_ov;
    logic [W-1:0]     r_oval;
    logic [POS_W-1:0] r_opos;
    logic             r_osing;
    logic             r_olast;

    always_ff @(posedge i_clk) begin
        r_oval  <= n_val;
        r_opos  <= n_tf.pos;
        r_osing <= n_tf.sing;
        r_olast <= n_tf.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[QB];
        end
    end

    assign o_valid    = r_ov;
    assign o_value    = $signed(r_oval);
    assign o_position = r_opos;
    assign o_singular = r_osing;
    assign o_last     = r_olast;

`ifndef SYNTHESIS
    // an accepted transaction holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accept");

    // a new matrix reaches the issuer only as the previous one finishes
    a_no_issue_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v6 |-> (!r_act || r_hsing || r_pos == LAST_POS))
        else $error("issuer overrun");

    // singular result is a lone zero at position zero
    a_singular_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_last && o_position == FIRST_POS && o_value == '0))
        else $error("malformed singular result");

    // last only on the final position of a regular matrix
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !o_singular) |-> (o_position == LAST_POS))
        else $error("last on wrong position");

    // results of one matrix come in consecutive cycles and positions
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_valid && o_position == POS_W'($past(o_position) + 1'b1)))
        else $error("result sequence broken");
`endif

endmodule
